@@ rtl/fpas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_pkg
// Shared types and constants for the single-precision add/subtract pipeline.
// ----------------------------------------------------------------------------
package fpas_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW  = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW  = 24;
    localparam logic [ExpW-1:0] ExpMax = 8'd255;
    localparam int unsigned DataW = 72;   // 32 + 32 + 1 packed to bytes

    // stage 1 -> 2: aligned significands
    typedef struct packed {
        logic            sa;
        logic            sb;
        logic [ExpW-1:0] e;
        logic [SigW-1:0] ma;
        logic [SigW-1:0] mb;
    } t_align;

    // stage 2 -> 3: raw sum or difference
    typedef struct packed {
        logic            rs;
        logic            zero;    // exact cancellation gives +0
        logic [ExpW:0]   e;       // may be 256 after carry
        logic [SigW-1:0] m;       // bit 23 set unless cancellation left it clear
    } t_sum;
endpackage

@@ rtl/fpas_align.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_align
// Unpack, apply mode, shift the significand of the smaller-exponent operand right.
// ----------------------------------------------------------------------------
module fpas_align (
    input  logic [fpas_pkg::WordW-1:0] i_a,
    input  logic [fpas_pkg::WordW-1:0] i_b,
    input  logic                       i_mode,
    output fpas_pkg::t_align           o_al
);
    logic [fpas_pkg::ExpW-1:0] ea, eb, d;
    logic [fpas_pkg::SigW-1:0] ma, mb;
    logic                      a_big;

    always_comb begin
        ea    = i_a[30:23];
        eb    = i_b[30:23];
        ma    = {1'b1, i_a[fpas_pkg::FracW-1:0]};
        mb    = {1'b1, i_b[fpas_pkg::FracW-1:0]};
        a_big = ea > eb;
        d     = a_big ? (ea - eb) : (eb - ea);
        o_al.sa = i_a[31];
        o_al.sb = i_b[31] ^ i_mode;
        o_al.e  = a_big ? ea : eb;
        o_al.ma = ma;
        o_al.mb = mb;
        if (a_big) begin
            o_al.mb = (d >= 8'd24) ? '0 : (mb >> d);
        end else begin
            o_al.ma = (d >= 8'd24) ? '0 : (ma >> d);
        end
    end
endmodule

@@ rtl/fpas_addsub.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_addsub
// Magnitude add or subtract, carry handling.
// ----------------------------------------------------------------------------
module fpas_addsub (
    input  fpas_pkg::t_align i_al,
    output fpas_pkg::t_sum   o_sum
);
    logic [fpas_pkg::SigW:0] s;
    logic                    a_ge;

    always_comb begin
        a_ge       = i_al.ma > i_al.mb;
        o_sum.zero = 1'b0;
        o_sum.e    = {1'b0, i_al.e};
        s          = '0;
        if (i_al.sa == i_al.sb) begin
            o_sum.rs = i_al.sa;
            s = {1'b0, i_al.ma} + {1'b0, i_al.mb};
            if (s[fpas_pkg::SigW]) begin
                s = s >> 1;
                o_sum.e = {1'b0, i_al.e} + 9'd1;
            end
        end else begin
            o_sum.rs   = a_ge ? i_al.sa : i_al.sb;
            o_sum.zero = i_al.ma == i_al.mb;
            s = a_ge ? ({1'b0, i_al.ma} - {1'b0, i_al.mb})
                     : ({1'b0, i_al.mb} - {1'b0, i_al.ma});
        end
        o_sum.m = s[fpas_pkg::SigW-1:0];
    end
endmodule

@@ rtl/fpas_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpas_norm
// Leading-one count, left shift, exponent range checks, packing.
// ----------------------------------------------------------------------------
module fpas_norm (
    input  fpas_pkg::t_sum             i_sum,
    output logic [fpas_pkg::WordW-1:0] o_res
);
    logic [4:0]              lz;
    logic [fpas_pkg::SigW-1:0] m;
    logic signed [9:0]       e;

    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < fpas_pkg::SigW; i++) begin
            if (i_sum.m[i]) lz = 5'(fpas_pkg::SigW - 1 - i);
        end
        m = i_sum.m << lz;
        e = $signed({1'b0, i_sum.e}) - $signed({5'd0, lz});
        if (i_sum.zero) o_res = '0;
        else if (e < 10'sd1) o_res = {i_sum.rs, 31'd0};
        else if (e >= 10'sd255) o_res = {i_sum.rs, fpas_pkg::ExpMax, 23'd0};
        else o_res = {i_sum.rs, e[7:0], m[fpas_pkg::FracW-1:0]};
    end
endmodule

@@ rtl/float32_add_subtract_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_add_subtract_core
// Pipelined single-precision add/subtract with truncation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per operand pair: tdata = {mode, b, a}
//   (a in bits 31:0). Master stream returns the 32-bit result pattern.
//   Four register stages: align, add/subtract, normalize, output.
//   m_axis_tvalid rises once an item accepted into the align register has
//   passed the add/subtract, normalize and output registers; throughput is
//   one item per cycle when not stalled, as all stage registers advance together.
//   When the receiver drops tready, the whole pipe holds (a global enable);
//   slave tready is high whenever the output stage is empty or being taken,
//   so nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; payload is kept.
//   No special handling of NaN, infinity or denormals; exponent underflow
//   flushes to signed zero and overflow gives signed infinity.
// ----------------------------------------------------------------------------
module float32_add_subtract_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [fpas_pkg::DataW-1:0]  s_axis_tdata,  // operand_a, operand_b, mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [fpas_pkg::WordW-1:0]  m_axis_tdata   // result_bits
);
    logic                        en;
    logic [3:0]                  r_v;
    fpas_pkg::t_align            n_al, r_al;
    fpas_pkg::t_sum              n_sum, r_sum;
    logic [fpas_pkg::WordW-1:0]  n_res, r_res, r_out;

    // pipe advances unless the output holds an untaken item
    assign en            = !r_v[3] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_v[3];
    assign m_axis_tdata  = r_out;

    fpas_align u_align (
        .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .i_mode(s_axis_tdata[64]), .o_al(n_al));
    fpas_addsub u_addsub (.i_al(r_al), .o_sum(n_sum));
    fpas_norm u_norm (.i_sum(r_sum), .o_res(n_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_al  <= n_al;
            r_sum <= n_sum;
            r_res <= n_res;
            r_out <= r_res;
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[0])
        else $error("accepted item not in stage 1");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled with empty output");
`endif
endmodule
